### src/qrs_pkg.sv
// qrs_pkg: shared types for the quadratic root solver.
// Root kind codes and the queue status group; no dependencies.
`default_nettype none

package qrs_pkg;

   typedef enum logic [1:0] {
      KIND_DISTINCT = 2'd0,
      KIND_EQUAL    = 2'd1,
      KIND_COMPLEX  = 2'd2,
      KIND_DEGEN    = 2'd3
   } qrs_kind_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qrs_fifo_stat_type;

endpackage

`default_nettype wire

### src/qrs_front.sv
// qrs_front: accepts coefficient items, forms the discriminant and classifies the roots.
// Three register stages; feeds the queue. Uses qrs_pkg.
`default_nettype none

module qrs_front #(
   parameter int COEF_WIDTH = 16,
   parameter int FRAC_BITS  = 16,
   parameter int IN_W       = 48,
   parameter int DATA_W     = 100
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [IN_W-1:0]              req_tdata,
   input  wire qrs_pkg::qrs_fifo_stat_type   fifo_stat,
   output logic                              push,
   output logic [DATA_W-1:0]                 push_data
);

   localparam int W   = COEF_WIDTH;
   localparam int DMW = 2 * W + 1;
   localparam int NBW = W + FRAC_BITS + 1;

   logic                   adv;
   logic signed [W-1:0]    a_in, b_in, c_in;
   logic signed [2*W-1:0]  bb_in, ac_in;

   logic                   vld1_ff, vld2_ff, vld3_ff;
   logic signed [W-1:0]    a1_ff, b1_ff;
   logic signed [2*W-1:0]  bb1_ff, ac1_ff;

   logic signed [2*W+1:0]  d_in;
   logic signed [NBW-1:0]  nb_in;
   logic signed [W:0]      negb;
   logic signed [2*W+1:0]  d2_ff;
   logic                   azero2_ff;
   logic signed [NBW-1:0]  nb2_ff, nb3_ff;
   logic signed [W:0]      den2_ff, den3_ff;

   logic [DMW-1:0]         dm_in, dm3_ff;
   qrs_pkg::qrs_kind_type  kind_in, kind3_ff;

   assign adv        = !vld3_ff || !fifo_stat.full;
   assign req_tready = adv;
   assign push       = vld3_ff && !fifo_stat.full;
   assign push_data  = {dm3_ff, nb3_ff, den3_ff, kind3_ff};

   assign a_in  = req_tdata[W-1:0];
   assign b_in  = req_tdata[2*W-1:W];
   assign c_in  = req_tdata[3*W-1:2*W];
   assign bb_in = b_in * b_in;
   assign ac_in = a_in * c_in;

   // d = b*b - 4ac, wide enough never to wrap
   assign d_in  = {{2{bb1_ff[2*W-1]}}, bb1_ff} - {ac1_ff, 2'b00};
   assign negb  = -{b1_ff[W-1], b1_ff};
   assign nb_in = {negb, {FRAC_BITS{1'b0}}};

   assign dm_in = d2_ff[2*W+1] ? DMW'(-d2_ff) : d2_ff[DMW-1:0];

   always_comb begin
      if (azero2_ff) begin
         kind_in = qrs_pkg::KIND_DEGEN;
      end else if (d2_ff[2*W+1]) begin
         kind_in = qrs_pkg::KIND_COMPLEX;
      end else if (d2_ff == '0) begin
         kind_in = qrs_pkg::KIND_EQUAL;
      end else begin
         kind_in = qrs_pkg::KIND_DISTINCT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= req_tvalid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff     <= a_in;
         b1_ff     <= b_in;
         bb1_ff    <= bb_in;
         ac1_ff    <= ac_in;
         d2_ff     <= d_in;
         azero2_ff <= (a1_ff == '0);
         nb2_ff    <= nb_in;
         den2_ff   <= {a1_ff, 1'b0};
         dm3_ff    <= dm_in;
         nb3_ff    <= nb2_ff;
         den3_ff   <= den2_ff;
         kind3_ff  <= kind_in;
      end
   end

endmodule

`default_nettype wire

### src/qrs_fifo.sv
// qrs_fifo: short queue between the classifying front and the arithmetic back.
// Four entries of register storage. Uses qrs_pkg for its status group.
`default_nettype none

module qrs_fifo #(
   parameter int DATA_W = 100
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire logic [DATA_W-1:0]           push_data,
   input  wire logic                        pop,
   output logic [DATA_W-1:0]                pop_data,
   output qrs_pkg::qrs_fifo_stat_type       stat
);

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]       count_ff, count_in;

   assign stat.full  = (count_ff == (PW+1)'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && stat.full)) else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && stat.empty)) else $error("queue read while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PW+1)'(DEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

### src/qrs_sqrt.sv
// qrs_sqrt: pipelined integer square root, one root bit per stage.
// Carries a side vector alongside each item. No package dependency.
`default_nettype none

module qrs_sqrt #(
   parameter int ROOT_W = 33,
   parameter int SIDE_W = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_vld,
   input  wire logic [2*ROOT_W-1:0]   in_rad,
   input  wire logic [SIDE_W-1:0]     in_side,
   output logic                       out_vld,
   output logic [ROOT_W-1:0]          out_root,
   output logic [SIDE_W-1:0]          out_side
);

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;

   logic              vld_ff  [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];

   genvar k;
   for (k = 0; k < ROOT_W; k++) begin : g_stage
      logic              vld_prev;
      logic [RAD_W-1:0]  rad_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [REM_W+1:0]  part, trial;
      logic              ge;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign vld_prev  = in_vld;
         assign rad_prev  = in_rad;
         assign root_prev = '0;
         assign rem_prev  = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      // bring down the next bit pair, try (root << 2) | 1
      assign part    = {rem_prev, rad_prev[RAD_W-1 -: 2]};
      assign trial   = {2'b00, root_prev, 2'b01};
      assign ge      = (part >= trial);
      assign rem_in  = ge ? REM_W'(part - trial) : part[REM_W-1:0];
      assign root_in = {root_prev[ROOT_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= {rad_prev[RAD_W-3:0], 2'b00};
            root_ff[k] <= root_in;
            rem_ff[k]  <= rem_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_vld  = vld_ff[ROOT_W-1];
   assign out_root = root_ff[ROOT_W-1];
   assign out_side = side_ff[ROOT_W-1];

endmodule

`default_nettype wire

### src/qrs_div.sv
// qrs_div: pipelined unsigned restoring divider, one quotient bit per stage.
// Carries a side vector alongside each item. No package dependency.
`default_nettype none

module qrs_div #(
   parameter int NUM_W  = 34,
   parameter int DEN_W  = 17,
   parameter int SIDE_W = 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_vld,
   input  wire logic [NUM_W-1:0]     in_num,
   input  wire logic [DEN_W-1:0]     in_den,
   input  wire logic [SIDE_W-1:0]    in_side,
   output logic                      out_vld,
   output logic [NUM_W-1:0]          out_quo,
   output logic [SIDE_W-1:0]         out_side
);

   logic              vld_ff  [NUM_W];
   logic [NUM_W-1:0]  num_ff  [NUM_W];
   logic [NUM_W-1:0]  quo_ff  [NUM_W];
   logic [DEN_W-1:0]  den_ff  [NUM_W];
   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   genvar k;
   for (k = 0; k < NUM_W; k++) begin : g_stage
      logic              vld_prev;
      logic [NUM_W-1:0]  num_prev, quo_prev;
      logic [DEN_W-1:0]  den_prev, rem_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DEN_W:0]    part;
      logic              ge;
      logic [DEN_W-1:0]  rem_in;

      if (k == 0) begin : g_first
         assign vld_prev  = in_vld;
         assign num_prev  = in_num;
         assign quo_prev  = '0;
         assign den_prev  = in_den;
         assign rem_prev  = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign num_prev  = num_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      assign part   = {rem_prev, num_prev[NUM_W-1]};
      assign ge     = (part >= {1'b0, den_prev});
      assign rem_in = ge ? DEN_W'(part - {1'b0, den_prev}) : part[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[k]  <= {num_prev[NUM_W-2:0], 1'b0};
            quo_ff[k]  <= {quo_prev[NUM_W-2:0], ge};
            den_ff[k]  <= den_prev;
            rem_ff[k]  <= rem_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_vld  = vld_ff[NUM_W-1];
   assign out_quo  = quo_ff[NUM_W-1];
   assign out_side = side_ff[NUM_W-1];

endmodule

`default_nettype wire

### src/qrs_back.sv
// qrs_back: square root, numerator forming, two dividers, clamping and result register.
// Uses qrs_pkg, qrs_sqrt and qrs_div.
`default_nettype none

module qrs_back #(
   parameter int COEF_WIDTH = 16,
   parameter int FRAC_BITS  = 16,
   parameter int DATA_W     = 100
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire qrs_pkg::qrs_fifo_stat_type  fifo_stat,
   input  wire logic [DATA_W-1:0]           pop_data,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [127:0]                     rsp_tdata,
   output logic [2:0]                       rsp_tuser
);

   localparam int W    = COEF_WIDTH;
   localparam int DMW  = 2 * W + 1;
   localparam int NBW  = W + FRAC_BITS + 1;
   localparam int SW   = W + FRAC_BITS + 1;
   localparam int NSW  = W + FRAC_BITS + 3;
   localparam int NW   = NSW - 1;
   localparam int DNW  = W + 1;
   localparam int SQSW = NBW + DNW + 2;
   localparam int CW   = (NW + 1 > 33) ? NW + 1 : 33;
   localparam logic signed [CW-1:0] MAXV = $signed({{(CW-31){1'b0}}, {31{1'b1}}});
   localparam logic signed [CW-1:0] MINV = $signed({{(CW-31){1'b1}}, {31{1'b0}}});

   logic en;

   // queue entry fields
   logic [DMW-1:0]        q_dm;
   logic signed [NBW-1:0] q_nb;
   logic signed [DNW-1:0] q_den;
   logic [1:0]            q_kind;

   logic                  sq_vld;
   logic [SW-1:0]         sq_root;
   logic [SQSW-1:0]       sq_side;
   logic signed [NBW-1:0] sq_nb;
   logic signed [DNW-1:0] sq_den;
   qrs_pkg::qrs_kind_type sq_kind;

   logic signed [NSW-1:0] nb_ext, s_ext, x_in, y_in;
   logic                  p1_vld_ff, p2_vld_ff, p3_vld_ff;
   logic signed [NSW-1:0] x1_ff, y1_ff;
   logic signed [DNW-1:0] den1_ff;
   qrs_pkg::qrs_kind_type kind1_ff, kind2_ff, kind3_ff;

   logic [NW-1:0]         xm2_ff, ym2_ff;
   logic [DNW-1:0]        denm2_ff;
   logic                  qsx2_ff, qsy2_ff;

   logic                  dx_vld, dy_vld;
   logic [NW-1:0]         qx, qy;
   logic                  dx_side;
   logic [2:0]            dy_side;
   qrs_pkg::qrs_kind_type dy_kind;

   logic signed [NW:0]    vx3_ff, vy3_ff, vny3_ff;

   logic [32:0]           cx, cy, cny;
   logic [31:0]           r1r_in, r1i_in, r2r_in, r2i_in;
   logic                  sat_in;
   logic                  rsp_valid_ff;
   logic [127:0]          rsp_data_ff;
   logic [2:0]            rsp_user_ff;

   function automatic logic [32:0] clamp32(input logic signed [CW-1:0] v);
      logic [32:0] r;
      if (v > MAXV) begin
         r = {1'b1, 32'h7fff_ffff};
      end else if (v < MINV) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   assign en  = !rsp_valid_ff || rsp_tready;
   assign pop = en && !fifo_stat.empty;

   assign {q_dm, q_nb, q_den, q_kind} = pop_data;

   qrs_sqrt #(
      .ROOT_W (SW),
      .SIDE_W (SQSW)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (pop),
      .in_rad   ({1'b0, q_dm, {(2*FRAC_BITS){1'b0}}}),
      .in_side  ({q_nb, q_den, q_kind}),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_side (sq_side)
   );

   assign sq_nb   = sq_side[SQSW-1 -: NBW];
   assign sq_den  = sq_side[DNW+1:2];
   assign sq_kind = qrs_pkg::qrs_kind_type'(sq_side[1:0]);

   assign nb_ext = {{2{sq_nb[NBW-1]}}, sq_nb};
   assign s_ext  = {2'b00, sq_root};

   // complex: real from -b alone, imaginary from the root; else -b +/- root
   always_comb begin
      if (sq_kind == qrs_pkg::KIND_COMPLEX) begin
         x_in = nb_ext;
         y_in = s_ext;
      end else begin
         x_in = nb_ext + s_ext;
         y_in = nb_ext - s_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
      end else if (en) begin
         p1_vld_ff <= sq_vld;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= dx_vld && dy_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff    <= x_in;
         y1_ff    <= y_in;
         den1_ff  <= sq_den;
         kind1_ff <= sq_kind;
         xm2_ff   <= x1_ff[NSW-1] ? NW'(-x1_ff) : x1_ff[NW-1:0];
         ym2_ff   <= y1_ff[NSW-1] ? NW'(-y1_ff) : y1_ff[NW-1:0];
         denm2_ff <= den1_ff[DNW-1] ? DNW'(-den1_ff) : DNW'(den1_ff);
         qsx2_ff  <= x1_ff[NSW-1] ^ den1_ff[DNW-1];
         qsy2_ff  <= y1_ff[NSW-1] ^ den1_ff[DNW-1];
         kind2_ff <= kind1_ff;
      end
   end

   qrs_div #(
      .NUM_W  (NW),
      .DEN_W  (DNW),
      .SIDE_W (1)
   ) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (p2_vld_ff),
      .in_num   (xm2_ff),
      .in_den   (denm2_ff),
      .in_side  (qsx2_ff),
      .out_vld  (dx_vld),
      .out_quo  (qx),
      .out_side (dx_side)
   );

   qrs_div #(
      .NUM_W  (NW),
      .DEN_W  (DNW),
      .SIDE_W (3)
   ) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (p2_vld_ff),
      .in_num   (ym2_ff),
      .in_den   (denm2_ff),
      .in_side  ({qsy2_ff, kind2_ff}),
      .out_vld  (dy_vld),
      .out_quo  (qy),
      .out_side (dy_side)
   );

   assign dy_kind = qrs_pkg::qrs_kind_type'(dy_side[1:0]);

   always_ff @(posedge clock) begin
      if (en) begin
         vx3_ff   <= dx_side    ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
         vy3_ff   <= dy_side[2] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
         vny3_ff  <= dy_side[2] ? $signed({1'b0, qy}) : -$signed({1'b0, qy});
         kind3_ff <= dy_kind;
      end
   end

   assign cx  = clamp32(CW'(vx3_ff));
   assign cy  = clamp32(CW'(vy3_ff));
   assign cny = clamp32(CW'(vny3_ff));

   always_comb begin
      unique case (kind3_ff) inside
         qrs_pkg::KIND_DISTINCT, qrs_pkg::KIND_EQUAL: begin
            r1r_in = cx[31:0];
            r1i_in = '0;
            r2r_in = cy[31:0];
            r2i_in = '0;
            sat_in = cx[32] | cy[32];
         end
         qrs_pkg::KIND_COMPLEX: begin
            r1r_in = cx[31:0];
            r1i_in = cy[31:0];
            r2r_in = cx[31:0];
            r2i_in = cny[31:0];
            sat_in = cx[32] | cy[32] | cny[32];
         end
         default: begin
            r1r_in = '0;
            r1i_in = '0;
            r2r_in = '0;
            r2i_in = '0;
            sat_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= p3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= {r2i_in, r2r_in, r1i_in, r1r_in};
         rsp_user_ff <= {sat_in, kind3_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_dividers_lockstep: assert property (@(posedge clock) disable iff (reset)
      dx_vld == dy_vld) else $error("divider pipelines out of step");
   a_degen_no_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff[1:0] == qrs_pkg::KIND_DEGEN) |-> !rsp_user_ff[2])
      else $error("degenerate result flagged as saturated");
   a_conjugate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff[1:0] == qrs_pkg::KIND_COMPLEX && !rsp_user_ff[2])
      |-> (rsp_data_ff[127:96] == 32'(-rsp_data_ff[63:32])))
      else $error("complex roots not conjugate");

endmodule

`default_nettype wire

### src/quadratic_root_solver.sv
// quadratic_root_solver: top level, roots of a*x^2 + b*x + c = 0 in Q16.16 style fixed point.
// Instantiates qrs_front, qrs_fifo and qrs_back; uses qrs_pkg.
//
// One item per clock cycle is accepted and one result per clock delivered, sustained while
// rsp_tready stays high. Items pass through three front stages forming b*b and a*c, the
// discriminant and the root kind, then the four-entry queue, COEF_WIDTH+FRAC_BITS+1
// square-root stages, two stages forming the numerators, COEF_WIDTH+FRAC_BITS+2 divider
// stages and two stages of sign, clamping and the result register. The back pipeline
// halts as a whole while a result waits; the front keeps taking items until the queue
// is full.
`default_nettype none

module quadratic_root_solver #(
   parameter int COEF_WIDTH = 16,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // coef_a, coef_b, coef_c from the lowest bit up, zero filled to whole bytes
   input  wire logic [((3*COEF_WIDTH+7)/8)*8-1:0]   req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // root_one_real, root_one_imag, root_two_real, root_two_imag
   output logic [127:0]                             rsp_tdata,
   // root_kind, saturated
   output logic [2:0]                               rsp_tuser
);

   localparam int IN_W   = ((3 * COEF_WIDTH + 7) / 8) * 8;
   localparam int DATA_W = (2 * COEF_WIDTH + 1) + (COEF_WIDTH + FRAC_BITS + 1)
                           + (COEF_WIDTH + 1) + 2;

   qrs_pkg::qrs_fifo_stat_type fifo_stat;
   logic                       push, pop;
   logic [DATA_W-1:0]          push_data, pop_data;

   qrs_front #(
      .COEF_WIDTH (COEF_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .IN_W       (IN_W),
      .DATA_W     (DATA_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .fifo_stat  (fifo_stat),
      .push       (push),
      .push_data  (push_data)
   );

   qrs_fifo #(
      .DATA_W (DATA_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (fifo_stat)
   );

   qrs_back #(
      .COEF_WIDTH (COEF_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .DATA_W     (DATA_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_stat  (fifo_stat),
      .pop_data   (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
